### hdl/range_encoder_with_carry_top_defines.svh
// ----------------------------------------------------------------------------
// range_encoder_with_carry_top_defines
// Assertion macros shared by the range encoder checkers.
// ----------------------------------------------------------------------------
`ifndef RANGE_ENCODER_WITH_CARRY_TOP_DEFINES_SVH
`define RANGE_ENCODER_WITH_CARRY_TOP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define REC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define REC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rec_pkg.sv
// ----------------------------------------------------------------------------
// rec_pkg
// Types and constants shared by the range encoder controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rec_pkg;

    // request codes carried on s_tuser
    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic [31:0] TOP_LIMIT   = 32'h0100_0000;
    localparam logic [31:0] HIGH_THRESH = 32'hFF00_0000;
    localparam logic [31:0] RANGE_INIT  = 32'hFFFF_FFFF;
    localparam logic [7:0]  PEND_ONES   = 8'hFF;
    localparam logic [7:0]  PEND_ZEROS  = 8'h00;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_CUM,
        ST_DIV_CUM,
        ST_ADD_LOW,
        ST_MUL_FRQ,
        ST_DIV_FRQ,
        ST_SET_RANGE,
        ST_NORM,
        ST_SHIFT,
        ST_PUT_CACHE,
        ST_PUT_PEND,
        ST_FLUSH_HOLD
    } state_t;

    typedef struct packed {
        logic capture;
        logic coder_clear;
        logic mul_load;
        logic mul_sel_frq;
        logic div_step;
        logic add_low;
        logic set_range;
        logic shift_range;
        logic put_cache;
        logic put_pend;
        logic resolve;
        logic defer;
        logic flush_hold;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       sym_ok;
        logic       div_done;
        logic       need_norm;
        logic       resolve_ok;
        logic       pend_zero;
        logic       can_put;
        logic       out_free;
        logic       hold_valid;
    } status_t;

endpackage

`default_nettype wire

### hdl/rec_datapath.sv
// ----------------------------------------------------------------------------
// rec_datapath
// Coder state, shared multiplier, radix-4 restoring divider, byte holdback
// and output register of the range encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module rec_datapath
    import rec_pkg::*;
#(
    parameter int FREQ_BITS   = 16,
    parameter int PENDING_MAX = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  s_tuser,
    input  wire logic [47:0] s_tdata,
    input  wire cmd_t        cmd,
    output status_t          status,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic [0:0]       m_tuser
);

    localparam int DW    = 32 + FREQ_BITS + (FREQ_BITS % 2);
    localparam int NSTEP = DW / 2;
    localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int PCW   = $clog2(PENDING_MAX + 1);

    function automatic logic [FREQ_BITS-1:0] fmask(input logic [15:0] v);
        logic [31:0] w;
        w = {16'd0, v};
        return w[FREQ_BITS-1:0];
    endfunction

    logic [1:0]           req_reg;
    logic [FREQ_BITS-1:0] cum_reg, frq_reg, tot_reg;

    logic [31:0]          range_reg, low_reg;
    logic                 carry_reg;
    logic [7:0]           cache_reg;
    logic [PCW-1:0]       pend_reg;
    logic                 ovf_reg;

    logic [DW-1:0]        dq_reg, dq_next;
    logic [FREQ_BITS-1:0] rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg;

    logic [7:0]           hold_byte_reg;
    logic                 hold_ovf_reg;
    logic                 hold_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_ovf_reg;
    logic                 out_last_reg;
    logic                 out_valid_reg;

    logic [FREQ_BITS-1:0]  mul_op;
    logic [31+FREQ_BITS:0] prod;
    logic [32:0]           low_sum;
    logic [7:0]            put_byte;
    logic                  out_free;

    // input latch
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_tuser;
            cum_reg <= fmask(s_tdata[15:0]);
            frq_reg <= fmask(s_tdata[31:16]);
            tot_reg <= fmask(s_tdata[47:32]);
        end
    end

    assign mul_op  = cmd.mul_sel_frq ? frq_reg : cum_reg;
    assign prod    = (32 + FREQ_BITS)'(range_reg) * (32 + FREQ_BITS)'(mul_op);
    assign low_sum = {1'b0, low_reg} + {1'b0, dq_reg[31:0]};

    // two restoring steps per cycle, quotient bits shift in from the bottom
    always_comb begin
        logic [FREQ_BITS:0] sh;
        rem_next = rem_reg;
        dq_next  = dq_reg;
        for (int k = 0; k < 2; k++) begin
            sh      = {rem_next, dq_next[DW-1]};
            dq_next = {dq_next[DW-2:0], 1'b0};
            if (sh >= {1'b0, tot_reg}) begin
                rem_next   = FREQ_BITS'(sh - {1'b0, tot_reg});
                dq_next[0] = 1'b1;
            end else begin
                rem_next = sh[FREQ_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            dq_reg  <= DW'(prod);
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // coder state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.coder_clear) begin
            range_reg <= RANGE_INIT;
            low_reg   <= '0;
            carry_reg <= 1'b0;
            cache_reg <= '0;
            pend_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cmd.add_low) begin
                low_reg   <= low_sum[31:0];
                carry_reg <= carry_reg | low_sum[32];
            end
            if (cmd.set_range) begin
                range_reg <= dq_reg[31:0];
            end
            if (cmd.shift_range) begin
                range_reg <= {range_reg[23:0], 8'd0};
            end
            if (cmd.put_pend) begin
                pend_reg <= pend_reg - PCW'(1);
            end
            if (cmd.resolve) begin
                cache_reg <= low_reg[31:24];
                carry_reg <= 1'b0;
                low_reg   <= {low_reg[23:0], 8'd0};
            end
            if (cmd.defer) begin
                if (pend_reg < PCW'(PENDING_MAX)) begin
                    pend_reg <= pend_reg + PCW'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
                low_reg <= {low_reg[23:0], 8'd0};
            end
        end
    end

    assign put_byte = cmd.put_cache ? cache_reg + {7'd0, carry_reg}
                                    : (carry_reg ? PEND_ZEROS : PEND_ONES);
    assign out_free = !out_valid_reg || m_tready;

    // one byte held back so the last one of a request can be marked
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.put_cache || cmd.put_pend) begin
                hold_byte_reg  <= put_byte;
                hold_ovf_reg   <= ovf_reg;
                hold_valid_reg <= 1'b1;
                if (hold_valid_reg) begin
                    out_byte_reg  <= hold_byte_reg;
                    out_ovf_reg   <= hold_ovf_reg;
                    out_last_reg  <= 1'b0;
                    out_valid_reg <= 1'b1;
                end else if (m_tready) begin
                    out_valid_reg <= 1'b0;
                end
            end else if (cmd.flush_hold) begin
                out_byte_reg   <= hold_byte_reg;
                out_ovf_reg    <= hold_ovf_reg;
                out_last_reg   <= 1'b1;
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_ovf_reg;

    always_comb begin
        status.req        = req_reg;
        status.sym_ok     = (tot_reg != '0) && (frq_reg != '0) &&
                            (({1'b0, cum_reg} + {1'b0, frq_reg}) <= {1'b0, tot_reg});
        status.div_done   = (cnt_reg == CW'(NSTEP - 1));
        status.need_norm  = (range_reg < TOP_LIMIT) && (range_reg != '0);
        status.resolve_ok = (low_reg < HIGH_THRESH) || carry_reg;
        status.pend_zero  = (pend_reg == '0);
        status.can_put    = !hold_valid_reg || out_free;
        status.out_free   = out_free;
        status.hold_valid = hold_valid_reg;
    end

endmodule

`default_nettype wire

### hdl/rec_ctrl.sv
// ----------------------------------------------------------------------------
// rec_ctrl
// Sequencer of the range encoder: decodes a request and steps the datapath
// through multiply, divide, normalize and byte shift-out.
// ----------------------------------------------------------------------------
`default_nettype none

module rec_ctrl
    import rec_pkg::*;
#(
    parameter int FLUSH_BYTES = 5
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam int FCW = (FLUSH_BYTES > 1) ? $clog2(FLUSH_BYTES) : 1;

    state_t         state_reg, state_next;
    logic [FCW-1:0] flush_cnt_reg;
    logic           step_done;
    logic           flush_last;
    state_t         ret_state;

    // one shift-out step of low is complete
    assign step_done  = ((state_reg == ST_SHIFT) && !status.resolve_ok) ||
                        ((state_reg == ST_PUT_PEND) && status.pend_zero);
    assign flush_last = (flush_cnt_reg == FCW'(FLUSH_BYTES - 1));
    assign ret_state  = (status.req == REQ_FINISH)
                        ? (flush_last ? ST_FLUSH_HOLD : ST_SHIFT) : ST_NORM;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DECODE) begin
            flush_cnt_reg <= '0;
        end else if (step_done && status.req == REQ_FINISH && !flush_last) begin
            flush_cnt_reg <= flush_cnt_reg + FCW'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.req)
                    REQ_ENCODE: state_next = status.sym_ok ? ST_MUL_CUM : ST_IDLE;
                    REQ_FINISH: state_next = ST_SHIFT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_MUL_CUM:   state_next = ST_DIV_CUM;
            ST_DIV_CUM: begin
                if (status.div_done) begin
                    state_next = ST_ADD_LOW;
                end
            end
            ST_ADD_LOW:   state_next = ST_MUL_FRQ;
            ST_MUL_FRQ:   state_next = ST_DIV_FRQ;
            ST_DIV_FRQ: begin
                if (status.div_done) begin
                    state_next = ST_SET_RANGE;
                end
            end
            ST_SET_RANGE: state_next = ST_NORM;
            ST_NORM:      state_next = status.need_norm ? ST_SHIFT : ST_FLUSH_HOLD;
            ST_SHIFT:     state_next = status.resolve_ok ? ST_PUT_CACHE : ret_state;
            ST_PUT_CACHE: begin
                if (status.can_put) begin
                    state_next = ST_PUT_PEND;
                end
            end
            ST_PUT_PEND: begin
                if (status.pend_zero) begin
                    state_next = ret_state;
                end
            end
            ST_FLUSH_HOLD: begin
                if (!status.hold_valid || status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // no request is taken while in reset
                s_tready    = aresetn;
                cmd.capture = s_tvalid;
            end
            ST_DECODE: begin
                cmd.coder_clear = (status.req == REQ_START);
            end
            ST_MUL_CUM: begin
                cmd.mul_load = 1'b1;
            end
            ST_DIV_CUM, ST_DIV_FRQ: begin
                cmd.div_step = 1'b1;
            end
            ST_ADD_LOW: begin
                cmd.add_low = 1'b1;
            end
            ST_MUL_FRQ: begin
                cmd.mul_load    = 1'b1;
                cmd.mul_sel_frq = 1'b1;
            end
            ST_SET_RANGE: begin
                cmd.set_range = 1'b1;
            end
            ST_NORM: begin
                cmd.shift_range = status.need_norm;
            end
            ST_SHIFT: begin
                cmd.defer = !status.resolve_ok;
            end
            ST_PUT_CACHE: begin
                cmd.put_cache = status.can_put;
            end
            ST_PUT_PEND: begin
                cmd.resolve  = status.pend_zero;
                cmd.put_pend = !status.pend_zero && status.can_put;
            end
            ST_FLUSH_HOLD: begin
                cmd.flush_hold = status.hold_valid && status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/range_encoder_with_carry_top.sv
// ----------------------------------------------------------------------------
// range_encoder_with_carry_top
// 32-bit range encoder with carry propagation and pending-byte handling.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one request at a time: s_tuser selects start, encode
//   or finish, s_tdata carries the cumulative, symbol and total frequencies.
//   The m_ channel returns the compressed stream one byte per beat; m_tlast
//   marks the final byte caused by a request, m_tuser flags pending overflow.
//   Start and ignored requests produce no bytes.
//   Encode runs the divider twice per symbol, two quotient bits a cycle,
//   then normalizes range, shifting out one byte of low per normalizing
//   shift. Finish shifts out FLUSH_BYTES bytes of low. The first byte
//   reaches m_tvalid after the divisions finish; the last one follows
//   when the request ends.
//   The block holds one byte back and owns a one-deep output register, so a
//   new request is taken while the final byte still waits on m_tready. When
//   the receiver stalls, byte emission pauses and no byte is lost.
//   Reset (aresetn low, synchronous) sets range to all ones and clears low,
//   carry, cache, pending count, overflow and both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module range_encoder_with_carry_top
    import rec_pkg::*;
#(
    parameter int FREQ_BITS   = 16,
    parameter int PENDING_MAX = 32,
    parameter int FLUSH_BYTES = 5
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // cum_freq[15:0], sym_freq[31:16], total_freq[47:32]
    input  wire logic [1:0]  s_tuser,  // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // out_byte[7:0]
    output logic             m_tlast,
    output logic [0:0]       m_tuser   // overflow[0]
);

    cmd_t    cmd;
    status_t status;

    rec_ctrl #(
        .FLUSH_BYTES (FLUSH_BYTES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rec_datapath #(
        .FREQ_BITS   (FREQ_BITS),
        .PENDING_MAX (PENDING_MAX)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### hdl/rec_checker.sv
// ----------------------------------------------------------------------------
// rec_checker
// Port-level checks of the range encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "range_encoder_with_carry_top_defines.svh"

module rec_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [0:0] m_tuser
);

    // a stalled byte stays offered
    `REC_ASSERT_NEXT(a_out_hold_valid, m_tvalid && !m_tready, m_tvalid, "byte dropped while stalled")

    // a stalled byte keeps its payload
    `REC_ASSERT_NEXT(a_out_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "payload changed while stalled")

    // a request is decoded before the next one is taken
    `REC_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken back to back")

    // bytes are only produced while a request is being worked on
    `REC_ASSERT_IMPL(a_byte_while_busy, $rose(m_tvalid), !$past(s_tready), "byte produced while idle")

endmodule

bind range_encoder_with_carry_top rec_checker u_rec_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 32-bit range encoder with carry. A queue-fed
// driver offers start, encode and finish requests. A bit-accurate encoder
// model, updated on each accepted request, predicts the stream bytes that
// the monitor checks one by one. Phases vary sender and receiver idling.
// Symbols are steered to straddle the carry boundary, which builds pending
// bytes up to saturation and then resolves them with or without a carry.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import rec_pkg::*;

    localparam int FREQ_W         = 16;
    localparam int PEND_CAP       = 32;
    localparam int FLUSH_N        = 5;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 90;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] cum;
        logic [15:0] frq;
        logic [15:0] tot;
    } coder_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } stream_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;  // cum_freq[15:0], sym_freq[31:16], total_freq[47:32]
    logic [1:0]  s_tuser  = '0;  // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // out_byte[7:0]
    logic        m_tlast;
    logic [0:0]  m_tuser;        // overflow[0]

    coder_req_t   req_q[$];
    coder_req_t   cur_req;
    stream_byte_t expected_bytes[$];
    stream_byte_t burst[$];

    // encoder state as the model sees it
    logic [31:0] enc_range;
    logic [31:0] enc_low;
    logic        enc_carry;
    logic [7:0]  enc_cache;
    int unsigned enc_pend;
    logic        enc_ovf;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int mismatch_cnt  = 0;
    int queued        = 0;

    range_encoder_with_carry_top #(
        .FREQ_BITS  (FREQ_W),
        .PENDING_MAX(PEND_CAP),
        .FLUSH_BYTES(FLUSH_N)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // encoder model
    // ------------------------------------------------------------------
    task automatic clear_coder();
        enc_range = RANGE_INIT;
        enc_low   = '0;
        enc_carry = 1'b0;
        enc_cache = '0;
        enc_pend  = 0;
        enc_ovf   = 1'b0;
    endtask

    task automatic emit_byte(input logic [7:0] value);
        stream_byte_t e;
        e.data = value;
        e.last = 1'b0;
        e.ovf  = enc_ovf;
        burst.push_back(e);
    endtask

    task automatic shift_low_byte();
        if (enc_low < HIGH_THRESH || enc_carry) begin
            emit_byte(enc_cache + {7'd0, enc_carry});
            while (enc_pend != 0) begin
                emit_byte(enc_carry ? PEND_ZEROS : PEND_ONES);
                enc_pend--;
            end
            enc_cache = enc_low[31:24];
            enc_carry = 1'b0;
        end else if (enc_pend < PEND_CAP) begin
            enc_pend++;
        end else begin
            enc_ovf = 1'b1;
        end
        enc_low = enc_low << 8;
    endtask

    task automatic encode_request(input coder_req_t r);
        logic [63:0] prod;
        logic [31:0] add;
        logic [31:0] old_low;
        int i;
        stream_byte_t e;
        burst.delete();
        case (r.kind)
            REQ_START: begin
                clear_coder();
            end
            REQ_ENCODE: begin
                if (r.tot != 0 && r.frq != 0 && {1'b0, r.cum} + {1'b0, r.frq} <= {1'b0, r.tot})
                begin
                    prod = 64'(enc_range);
                    prod = prod * 64'(r.cum) / 64'(r.tot);
                    add = prod[31:0];
                    old_low = enc_low;
                    enc_low = enc_low + add;
                    // a second carry before the first resolves keeps the flag at one
                    if (enc_low < old_low)
                        enc_carry = 1'b1;
                    prod = 64'(enc_range);
                    prod = prod * 64'(r.frq) / 64'(r.tot);
                    enc_range = prod[31:0];
                    while (enc_range < TOP_LIMIT && enc_range != 0) begin
                        enc_range = enc_range << 8;
                        shift_low_byte();
                    end
                end
            end
            REQ_FINISH: begin
                repeat (FLUSH_N) shift_low_byte();
            end
            default: ;
        endcase
        for (i = 0; i < burst.size(); i++) begin
            e = burst[i];
            e.last = (i == burst.size() - 1);
            expected_bytes.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------
    // driver, receiver, monitor, watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            clear_coder();
        end else begin
            if (s_tvalid && s_tready)
                encode_request(cur_req);
            if (!s_tvalid || s_tready) begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    cur_req = req_q.pop_front();
                    s_tdata  <= {cur_req.tot, cur_req.frq, cur_req.cum};
                    s_tuser  <= cur_req.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            // long hold-off so the block backs up into its input
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        stream_byte_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h last %0b ovf %0b",
                         $time, m_tdata, m_tlast, m_tuser[0]);
                mismatch_cnt++;
            end else begin
                e = expected_bytes.pop_front();
                if (m_tdata !== e.data) begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, e.data, m_tdata);
                    mismatch_cnt++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last mismatch, expected %0b, actual %0b",
                             $time, e.last, m_tlast);
                    mismatch_cnt++;
                end
                if (m_tuser[0] !== e.ovf) begin
                    $display("%0t: overflow mismatch, expected %0b, actual %0b",
                             $time, e.ovf, m_tuser[0]);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("range_encoder_with_carry_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [1:0] kind, input logic [15:0] cum,
                             input logic [15:0] frq, input logic [15:0] tot);
        coder_req_t r;
        r.kind = kind;
        r.cum  = cum;
        r.frq  = frq;
        r.tot  = tot;
        req_q.push_back(r);
        queued++;
    endtask

    task automatic wait_sender_idle();
        do @(negedge aclk); while (req_q.size() != 0 || s_tvalid);
    endtask

    task automatic wait_all_done();
        do @(negedge aclk);
        while (req_q.size() != 0 || s_tvalid || expected_bytes.size() != 0);
    endtask

    task automatic queue_symbol();
        int t;
        int f;
        int c;
        case ($urandom_range(0, 3))
            0:       t = $urandom_range(1, 255);
            1:       t = $urandom_range(65000, 65535);
            default: t = $urandom_range(256, 65535);
        endcase
        f = ($urandom_range(0, 1) != 0) ? $urandom_range(1, (t < 16) ? t : 16)
                                        : $urandom_range(1, t);
        c = $urandom_range(0, t - f);
        queue_req(REQ_ENCODE, 16'(c), 16'(f), 16'(t));
    endtask

    task automatic queue_bad_symbol();
        int t;
        int f;
        int c;
        case ($urandom_range(0, 2))
            0: queue_req(REQ_ENCODE, 16'($urandom), 16'($urandom), 16'd0);
            1: queue_req(REQ_ENCODE, 16'($urandom), 16'd0, 16'($urandom));
            default: begin
                t = $urandom_range(1, 65534);
                f = $urandom_range(1, 65535);
                c = (f > t) ? $urandom_range(0, 65535) : $urandom_range(t - f + 1, 65535);
                queue_req(REQ_ENCODE, 16'(c), 16'(f), 16'(t));
            end
        endcase
    endtask

    task automatic queue_stream();
        int n;
        int k;
        int pick;
        n = $urandom_range(3, 20);
        if ($urandom_range(0, 99) < 80)
            queue_req(REQ_START, 16'($urandom), 16'($urandom), 16'($urandom));
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                queue_bad_symbol();
            else if (pick < 8)
                queue_req(REQ_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
            else
                queue_symbol();
        end
        if ($urandom_range(0, 99) < 85)
            queue_req(REQ_FINISH, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // picks a symbol whose subinterval still holds the carry boundary, so each
    // shifted byte turns pending; with want_carry the symbol lies above it
    task automatic queue_straddle(input bit want_carry);
        logic [32:0]     gap_to_top;
        logic [63:0]     prod;
        longint unsigned c0;
        int t;
        int f;
        int c;
        wait_sender_idle();
        t = $urandom_range(32768, 65535);
        gap_to_top = 33'h1_0000_0000 - {1'b0, enc_low};
        if ({1'b0, enc_low} + {1'b0, enc_range} > 33'h1_0000_0000) begin
            prod = 64'(gap_to_top) * 64'(t);
            c0 = prod / 64'(enc_range);
            if (want_carry) begin
                f = 1;
                c = int'(c0 + 1);
            end else begin
                f = $urandom_range(4, 16);
                c = (c0 != 0) ? int'(c0 - 1) : 0;
            end
            if (c + f > t)
                c = t - f;
        end else begin
            f = $urandom_range(4, 16);
            c = $urandom_range(0, t - f);
        end
        queue_req(REQ_ENCODE, 16'(c), 16'(f), 16'(t));
    endtask

    task automatic queue_pending_run();
        int n;
        int k;
        n = $urandom_range(18, 34);
        queue_req(REQ_START, 16'd0, 16'd0, 16'd0);
        for (k = 0; k < n; k++)
            queue_straddle(1'b0);
        queue_straddle($urandom_range(0, 1));
        queue_req(REQ_FINISH, 16'd0, 16'd0, 16'd0);
    endtask

    initial begin
        int phase;
        int target;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: field extremes, ignored requests, flush corner cases
        queue_req(REQ_START,  16'h0000, 16'h0000, 16'h0000);
        queue_req(REQ_ENCODE, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_req(REQ_ENCODE, 16'h0000, 16'h0001, 16'hFFFF);
        queue_req(REQ_ENCODE, 16'hFFFE, 16'h0001, 16'hFFFF);
        queue_req(REQ_ENCODE, 16'h0000, 16'h0001, 16'h0001);
        queue_req(REQ_ENCODE, 16'h5555, 16'h2AAA, 16'hFFFF);
        queue_req(REQ_ENCODE, 16'hAAAA, 16'h5555, 16'hFFFF);
        queue_req(REQ_ENCODE, 16'h0000, 16'h0001, 16'h0000);
        queue_req(REQ_ENCODE, 16'h0000, 16'h0000, 16'd100);
        queue_req(REQ_ENCODE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(REQ_ENCODE, 16'd50,   16'd51,   16'd100);
        queue_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(REQ_ENCODE, 16'd1,    16'd1,    16'd2);
        queue_req(REQ_FINISH, 16'h0000, 16'h0000, 16'h0000);
        queue_req(REQ_FINISH, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // encode after a flush without a fresh start
        queue_req(REQ_ENCODE, 16'd7,    16'd3,    16'd12);
        queue_req(REQ_START,  16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(REQ_FINISH, 16'h0000, 16'h0000, 16'h0000);
        queue_req(REQ_START,  16'h0000, 16'h0000, 16'h0000);
        queue_req(REQ_ENCODE, 16'd254,  16'd1,    16'd255);
        queue_req(REQ_ENCODE, 16'd0,    16'd1,    16'd256);
        queue_req(REQ_ENCODE, 16'd65533, 16'd2,   16'hFFFF);
        queue_req(REQ_FINISH, 16'h0000, 16'h0000, 16'h0000);
        wait_all_done();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            if (phase == 0)
                hold_requests++;
            target = queued + PHASE_ITEMS;
            while (queued < target - PHASE_ITEMS / 2)
                queue_stream();
            queue_pending_run();
            while (queued < target)
                queue_stream();
            wait_all_done();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && expected_bytes.size() == 0) begin
            $display("range_encoder_with_carry_top regression: pass");
        end else begin
            $display("range_encoder_with_carry_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
